[hdl/assert_macros.svh]
// assertion macros used by the top level rtl file
// no dependencies; bodies compile away when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AST_HOLDS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define AST_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define AST_HOLDS(lbl, clk, rstn, expr, msg)
`define AST_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[hdl/w2s_pkg.sv]
// shared constants, beat types and stage types of the world to screen projector
// no dependencies
package w2s_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int REJECT_EPSILON = 66;

    localparam int DIMW = 16;
    localparam int CW   = 66 - FRAC_BITS;
    localparam int MW   = CW + 1;
    localparam int PW   = MW + DIMW;
    localparam int QB   = (FRAC_BITS + 19 > 33) ? FRAC_BITS + 19 : 33;
    localparam int RW   = MW + QB;
    localparam int LW   = DIMW + 2 + FRAC_BITS;

    localparam int MIN_W_RAW = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int MIN_W     = (MIN_W_RAW < 1) ? 1 : MIN_W_RAW;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_LO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X_HI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_LO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y_HI    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W_LO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_W_HI    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT= 3'd7;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic               clamp_mode;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               valid_res;
    } out_beat_t;

    typedef struct packed {
        logic [63:0]     row_x_lo;
        logic [63:0]     row_x_hi;
        logic [63:0]     row_y_lo;
        logic [63:0]     row_y_hi;
        logic [63:0]     row_w_lo;
        logic [63:0]     row_w_hi;
        logic [DIMW-1:0] frame_width;
        logic [DIMW-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cw;
        logic                 clamp;
    } clip_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic clamp;
        logic reject;
    } div_tag_t;

    typedef struct packed {
        logic [RW-1:0] num_x;
        logic [RW-1:0] num_y;
        logic [MW-1:0] den;
        div_tag_t      tag;
    } div_in_t;

    typedef struct packed {
        logic [RW-1:0] rem_x;
        logic [RW-1:0] rem_y;
        logic [QB-1:0] q_x;
        logic [QB-1:0] q_y;
        logic [MW-1:0] den;
        div_tag_t      tag;
    } div_stage_t;

    typedef struct packed {
        logic [QB-1:0] q_x;
        logic [QB-1:0] q_y;
        logic          ovf_x;
        logic          ovf_y;
        div_tag_t      tag;
    } div_out_t;

endpackage

[hdl/w2s_clip.sv]
// clip x, y and w from three matrix rows: product stage then sum stage
// depends on w2s_pkg
module w2s_clip
    import w2s_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     ce,
    input  logic     in_valid,
    input  in_beat_t in_beat,
    input  cfg_t     cfg,
    output logic     clip_valid,
    output clip_t    clip
);

    logic signed [31:0] coef [9];
    logic signed [31:0] coord [3];
    logic signed [63:0] prod_reg [9];
    logic               clamp1_reg;
    logic               vld1_reg;
    clip_t              clip_reg;
    clip_t              clip_next;
    logic               vld2_reg;

    function automatic logic signed [CW-1:0] row_sum(
        input logic signed [31:0] t,
        input logic signed [63:0] p0,
        input logic signed [63:0] p1,
        input logic signed [63:0] p2
    );
        return CW'(t) + CW'(p0 >>> FRAC_BITS) + CW'(p1 >>> FRAC_BITS)
            + CW'(p2 >>> FRAC_BITS);
    endfunction

    always_comb begin
        coef[0]  = cfg.row_x_lo[31:0];
        coef[1]  = cfg.row_x_lo[63:32];
        coef[2]  = cfg.row_x_hi[31:0];
        coef[3]  = cfg.row_y_lo[31:0];
        coef[4]  = cfg.row_y_lo[63:32];
        coef[5]  = cfg.row_y_hi[31:0];
        coef[6]  = cfg.row_w_lo[31:0];
        coef[7]  = cfg.row_w_lo[63:32];
        coef[8]  = cfg.row_w_hi[31:0];
        coord[0] = in_beat.world_x;
        coord[1] = in_beat.world_y;
        coord[2] = in_beat.world_z;
    end

    always_comb begin
        clip_next.cx    = row_sum(cfg.row_x_hi[63:32], prod_reg[0], prod_reg[1], prod_reg[2]);
        clip_next.cy    = row_sum(cfg.row_y_hi[63:32], prod_reg[3], prod_reg[4], prod_reg[5]);
        clip_next.cw    = row_sum(cfg.row_w_hi[63:32], prod_reg[6], prod_reg[7], prod_reg[8]);
        clip_next.clamp = clamp1_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 9; k++) begin
                prod_reg[k] <= 64'(coef[k]) * 64'(coord[k % 3]);
            end
            clamp1_reg <= in_beat.clamp_mode;
            clip_reg   <= clip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else if (ce) begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    assign clip_valid = vld2_reg;
    assign clip       = clip_reg;

endmodule

[hdl/w2s_prep.sv]
// w select and reject test, viewport offset and magnitude, scale by frame size
// depends on w2s_pkg
module w2s_prep
    import w2s_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    ce,
    input  logic    clip_valid,
    input  clip_t   clip,
    input  cfg_t    cfg,
    output logic    div_valid,
    output div_in_t div_in
);

    logic signed [CW-1:0] w3;
    logic                 rej3;
    logic signed [CW-1:0] cx3_reg, cy3_reg, w3_reg;
    logic                 clamp3_reg, rej3_reg;

    logic signed [MW-1:0] nx4, ny4;
    logic [MW-1:0]        mag_x4_reg, mag_y4_reg;
    logic signed [CW-1:0] w4_reg;
    div_tag_t             tag4_reg;

    logic [PW-1:0]        px5, py5;
    div_in_t              div_in_reg;
    logic [2:0]           vld_reg;

    always_comb begin
        w3   = clip.cw;
        rej3 = 1'b0;
        if (clip.clamp) begin
            if (clip.cw < CW'(MIN_W)) begin
                w3 = CW'(MIN_W);
            end
        end else if (clip.cw <= CW'(REJECT_EPSILON) || clip.cw <= 0) begin
            rej3 = 1'b1;
            w3   = CW'(1);
        end
    end

    always_comb begin
        nx4 = MW'(cx3_reg) + MW'(w3_reg);
        ny4 = MW'(cy3_reg) + MW'(w3_reg);
        px5 = PW'(mag_x4_reg) * PW'(cfg.frame_width);
        py5 = PW'(mag_y4_reg) * PW'(cfg.frame_height);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cx3_reg    <= clip.cx;
            cy3_reg    <= clip.cy;
            w3_reg     <= w3;
            clamp3_reg <= clip.clamp;
            rej3_reg   <= rej3;

            mag_x4_reg      <= nx4[MW-1] ? MW'(-nx4) : MW'(nx4);
            mag_y4_reg      <= ny4[MW-1] ? MW'(-ny4) : MW'(ny4);
            w4_reg          <= w3_reg;
            tag4_reg.neg_x  <= nx4[MW-1];
            tag4_reg.neg_y  <= ny4[MW-1];
            tag4_reg.clamp  <= clamp3_reg;
            tag4_reg.reject <= rej3_reg;

            div_in_reg.num_x <= RW'(px5) << FRAC_BITS;
            div_in_reg.num_y <= RW'(py5) << FRAC_BITS;
            div_in_reg.den   <= MW'({w4_reg, 1'b0});
            div_in_reg.tag   <= tag4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[1:0], clip_valid};
        end
    end

    assign div_valid = vld_reg[2];
    assign div_in    = div_in_reg;

endmodule

[hdl/w2s_div.sv]
// restoring divider for both axes, one quotient bit per stage, then overflow test
// depends on w2s_pkg
module w2s_div
    import w2s_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     ce,
    input  logic     din_valid,
    input  div_in_t  din,
    output logic     dout_valid,
    output div_out_t dout
);

    div_stage_t    st_reg  [QB];
    div_stage_t    st_next [QB];
    logic [QB-1:0] vld_reg;
    div_out_t      out_reg;
    logic          out_vld_reg;

    always_comb begin
        div_stage_t    cur;
        logic [RW-1:0] tx;
        for (int k = 0; k < QB; k++) begin
            if (k == 0) begin
                cur.rem_x = din.num_x;
                cur.rem_y = din.num_y;
                cur.q_x   = '0;
                cur.q_y   = '0;
                cur.den   = din.den;
                cur.tag   = din.tag;
            end else begin
                cur = st_reg[k-1];
            end
            st_next[k] = cur;
            tx = RW'(cur.den) << (QB - 1 - k);
            if (cur.rem_x >= tx) begin
                st_next[k].rem_x          = cur.rem_x - tx;
                st_next[k].q_x[QB - 1 - k] = 1'b1;
            end
            if (cur.rem_y >= tx) begin
                st_next[k].rem_y          = cur.rem_y - tx;
                st_next[k].q_y[QB - 1 - k] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < QB; k++) begin
                st_reg[k] <= st_next[k];
            end
            out_reg.q_x   <= st_reg[QB-1].q_x;
            out_reg.q_y   <= st_reg[QB-1].q_y;
            out_reg.ovf_x <= st_reg[QB-1].rem_x >= RW'(st_reg[QB-1].den);
            out_reg.ovf_y <= st_reg[QB-1].rem_y >= RW'(st_reg[QB-1].den);
            out_reg.tag   <= st_reg[QB-1].tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg     <= {vld_reg[QB-2:0], din_valid};
            out_vld_reg <= vld_reg[QB-1];
        end
    end

    assign dout_valid = out_vld_reg;
    assign dout       = out_reg;

endmodule

[hdl/w2s_out.sv]
// sign, clamp and saturation of the quotients, zero for rejected beats, two-entry output buffer
// depends on w2s_pkg
module w2s_out
    import w2s_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      din_valid,
    input  div_out_t  din,
    input  cfg_t      cfg,
    output logic      ce,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_beat
);

    localparam logic [QB:0] POS_MAX = (QB + 1)'(33'h0_7FFF_FFFF);
    localparam logic [QB:0] NEG_MAG = (QB + 1)'(33'h0_8000_0000);

    logic [DIMW-1:0] dim_max;
    logic [QB:0]     lim;
    out_beat_t       res;
    out_beat_t       buf_reg [2];
    logic [1:0]      count_reg;
    logic            push, pop;

    function automatic logic [31:0] finish(
        input logic [QB-1:0] q,
        input logic          ovf,
        input logic          neg,
        input logic          clamp,
        input logic [QB:0]   limit
    );
        logic [QB:0] m;
        logic [31:0] r;
        m = ovf ? '1 : {1'b0, q};
        if (clamp && m > limit) begin
            m = limit;
        end
        if (!neg) begin
            r = (m > POS_MAX) ? 32'h7FFF_FFFF : m[31:0];
        end else begin
            r = (m > NEG_MAG) ? 32'h8000_0000 : ~m[31:0] + 32'd1;
        end
        return r;
    endfunction

    always_comb begin
        dim_max = (cfg.frame_width > cfg.frame_height) ? cfg.frame_width : cfg.frame_height;
        lim     = (QB + 1)'({dim_max, 2'b00}) << FRAC_BITS;
        if (din.tag.reject) begin
            res.screen_x  = '0;
            res.screen_y  = '0;
            res.valid_res = 1'b0;
        end else begin
            res.screen_x  = finish(din.q_x, din.ovf_x, din.tag.neg_x, din.tag.clamp, lim);
            res.screen_y  = finish(din.q_y, din.ovf_y, din.tag.neg_y, din.tag.clamp, lim);
            res.valid_res = 1'b1;
        end
    end

    assign ce      = (count_reg != 2'd2);
    assign push    = ce && din_valid;
    assign m_valid = (count_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign m_beat  = buf_reg[0];

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b10: begin
                buf_reg[count_reg[0]] <= res;
            end
            2'b01: begin
                buf_reg[0] <= buf_reg[1];
            end
            2'b11: begin
                if (count_reg == 2'd1) begin
                    buf_reg[0] <= res;
                end else begin
                    buf_reg[0] <= buf_reg[1];
                    buf_reg[1] <= res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

[hdl/world_to_screen_projector.sv]
// top level of the world to screen projector: config registers and pipeline
// depends on w2s_pkg, w2s_clip, w2s_prep, w2s_div, w2s_out, assert_macros.svh
//
//  channel   ports                      beat
//  input     s_valid s_ready s_beat     in_beat_t: world x, y, z, clamp mode
//  output    m_valid m_ready m_beat     out_beat_t: screen x, y, valid flag
//  config    cfg_we cfg_index cfg_wdata one register write, no handshake
//
// one beat per cycle unless the output buffer is full; m_valid rises once
// the beat has passed clip, prep, the one-bit-per-stage divider and the buffer
// reset is synchronous on aresetn and clears all valid bits and the output buffer
// the whole pipeline holds while its two-entry output buffer is full, so
// s_ready falls only after two results wait untaken
`include "assert_macros.svh"

module world_to_screen_projector
    import w2s_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_beat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_beat,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_wdata
);

    cfg_t     cfg_reg;
    logic     ce;
    logic     clip_valid;
    clip_t    clip;
    logic     div_valid;
    div_in_t  div_in;
    logic     dout_valid;
    div_out_t dout;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_x_lo     <= 64'h0000_0001_0000_0000;
            cfg_reg.row_x_hi     <= 64'h0;
            cfg_reg.row_y_lo     <= 64'h0001_0000_0000_0000;
            cfg_reg.row_y_hi     <= 64'h0;
            cfg_reg.row_w_lo     <= 64'h0;
            cfg_reg.row_w_hi     <= 64'h0000_0000_0001_0000;
            cfg_reg.frame_width  <= 16'd640;
            cfg_reg.frame_height <= 16'd480;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROW_X_LO:     cfg_reg.row_x_lo     <= cfg_wdata;
                REG_ROW_X_HI:     cfg_reg.row_x_hi     <= cfg_wdata;
                REG_ROW_Y_LO:     cfg_reg.row_y_lo     <= cfg_wdata;
                REG_ROW_Y_HI:     cfg_reg.row_y_hi     <= cfg_wdata;
                REG_ROW_W_LO:     cfg_reg.row_w_lo     <= cfg_wdata;
                REG_ROW_W_HI:     cfg_reg.row_w_hi     <= cfg_wdata;
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_wdata[DIMW-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_wdata[DIMW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = ce;

    w2s_clip u_clip (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (s_valid),
        .in_beat    (s_beat),
        .cfg        (cfg_reg),
        .clip_valid (clip_valid),
        .clip       (clip)
    );

    w2s_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .clip_valid (clip_valid),
        .clip       (clip),
        .cfg        (cfg_reg),
        .div_valid  (div_valid),
        .div_in     (div_in)
    );

    w2s_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .din_valid  (div_valid),
        .din        (div_in),
        .dout_valid (dout_valid),
        .dout       (dout)
    );

    w2s_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .din_valid (dout_valid),
        .din       (dout),
        .cfg       (cfg_reg),
        .ce        (ce),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat)
    );

    `AST_IMPLIES(a_stall_needs_result, aclk, aresetn, !s_ready, m_valid, "stall without result")
    `AST_IMPLIES(a_reject_zero, aclk, aresetn, m_valid && !m_beat.valid_res, m_beat.screen_x == 0 && m_beat.screen_y == 0, "rejected beat not zero")
    `AST_IMPLIES(a_ready_after_pop, aclk, aresetn, $rose(s_ready), $past(m_valid && m_ready), "ready rose without pop")

endmodule
